[rtl/lfsc_pkg.sv]
package lfsc_pkg;

	// Configuration port
	localparam int CFG_AW = 5;
	localparam logic [2:0] REG_TRACK_WIDTH  = 3'd0;
	localparam logic [2:0] REG_INV_SPACING  = 3'd1;
	localparam logic [2:0] REG_OFFSET_GAIN  = 3'd2;
	localparam logic [2:0] REG_HEADING_GAIN = 3'd3;
	localparam logic [2:0] REG_BASE_POWER   = 3'd4;
	localparam logic [2:0] REG_MIN_POWER    = 3'd5;
	localparam logic [2:0] REG_MAX_POWER    = 3'd6;

	// Register reset values
	localparam logic [23:0]        RST_TRACK_WIDTH  = 24'd1677722;
	localparam logic [15:0]        RST_INV_SPACING  = 16'd1910;
	localparam logic signed [23:0] RST_OFFSET_GAIN  = -24'sd768000;
	localparam logic signed [23:0] RST_HEADING_GAIN = -24'sd21069;
	localparam logic [7:0]         RST_BASE_POWER   = 8'd235;
	localparam logic [7:0]         RST_MIN_POWER    = 8'd0;
	localparam logic [7:0]         RST_MAX_POWER    = 8'd255;

	// Fixed arithmetic constants
	localparam int SCALE_W       = 24;
	localparam int MUL_B_W       = SCALE_W + 1;
	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
	localparam int FRONT_OFFSET  = 20;
	localparam int CORR_MAX      = 32767;
	localparam int CORR_W        = 16;
	localparam int WHEEL_W       = 17;
	localparam int HI_SHIFT      = 32;
	localparam int SAT_LIMIT_BIT = 29;
	localparam int HEADING_SHIFT = 8;
	localparam int GAIN_FRAC     = 8;

	// Stream payload layout
	localparam int M_TDATA_W = 24;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_BUTTON = 1'b1;

	// Wheel direction codes
	localparam logic [1:0] DIR_FWD   = 2'd0;
	localparam logic [1:0] DIR_REV   = 2'd1;
	localparam logic [1:0] DIR_BRAKE = 2'd2;

	typedef enum logic [2:0] {
		PH_UNCAL,
		PH_DARK,
		PH_REF,
		PH_SCALE,
		PH_RUN
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL_Y,
		ST_MUL_T,
		ST_MUL_HF,
		ST_MUL_G1,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_ACC,
		ST_CORR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [23:0]        track_width;
		logic [15:0]        inv_spacing;
		logic signed [23:0] offset_gain;
		logic signed [23:0] heading_gain;
		logic [7:0]         base_power;
		logic [7:0]         min_power;
		logic [7:0]         max_power;
	} cfg_t;

	typedef struct packed {
		logic [1:0] dir;
		logic [7:0] power;
	} wheel_t;

	// Map a signed wheel command to power and direction with dead band and clamp
	function automatic wheel_t drive(input logic signed [WHEEL_W-1:0] v,
			input logic [7:0] min_p, input logic [7:0] max_p);
		wheel_t w;
		logic [WHEEL_W-1:0] mag;
		if (v[WHEEL_W-1]) begin
			w.dir = DIR_REV;
			mag = WHEEL_W'(-v);
		end else if (v != '0) begin
			w.dir = DIR_FWD;
			mag = v;
		end else begin
			w.dir = DIR_BRAKE;
			mag = '0;
		end
		if (mag < WHEEL_W'(min_p)) begin
			w.power = '0;
			w.dir = DIR_BRAKE;
		end else if (mag > WHEEL_W'(max_p)) begin
			w.power = max_p;
		end else begin
			w.power = mag[7:0];
		end
		return w;
	endfunction

endpackage

[rtl/lfsc_cfg.sv]
module lfsc_cfg import lfsc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[CFG_AW-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// Write registers on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.track_width  <= RST_TRACK_WIDTH;
			cfg_q.inv_spacing  <= RST_INV_SPACING;
			cfg_q.offset_gain  <= RST_OFFSET_GAIN;
			cfg_q.heading_gain <= RST_HEADING_GAIN;
			cfg_q.base_power   <= RST_BASE_POWER;
			cfg_q.min_power    <= RST_MIN_POWER;
			cfg_q.max_power    <= RST_MAX_POWER;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TRACK_WIDTH:  cfg_q.track_width  <= pwdata[23:0];
				REG_INV_SPACING:  cfg_q.inv_spacing  <= pwdata[15:0];
				REG_OFFSET_GAIN:  cfg_q.offset_gain  <= signed'(pwdata[23:0]);
				REG_HEADING_GAIN: cfg_q.heading_gain <= signed'(pwdata[23:0]);
				REG_BASE_POWER:   cfg_q.base_power   <= pwdata[7:0];
				REG_MIN_POWER:    cfg_q.min_power    <= pwdata[7:0];
				REG_MAX_POWER:    cfg_q.max_power    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read back, gains sign-extended
	always_comb begin
		case (reg_idx)
			REG_TRACK_WIDTH:  prdata = {8'd0, cfg_q.track_width};
			REG_INV_SPACING:  prdata = {16'd0, cfg_q.inv_spacing};
			REG_OFFSET_GAIN:  prdata = {{8{cfg_q.offset_gain[23]}}, cfg_q.offset_gain};
			REG_HEADING_GAIN: prdata = {{8{cfg_q.heading_gain[23]}}, cfg_q.heading_gain};
			REG_BASE_POWER:   prdata = {24'd0, cfg_q.base_power};
			REG_MIN_POWER:    prdata = {24'd0, cfg_q.min_power};
			REG_MAX_POWER:    prdata = {24'd0, cfg_q.max_power};
			default:          prdata = '0;
		endcase
	end

endmodule

[rtl/lfsc_mul.sv]
module lfsc_mul #(
	parameter int AW = 37,
	parameter int BW = 25
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p_q
);

	// Registered signed product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

[rtl/lfsc_div.sv]
module lfsc_div #(
	parameter int NW = 24,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done_q,
	output logic [NW-1:0] quo_q
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// One quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

endmodule

[rtl/line_follow_steering_controller.sv]
// Steering controller for a line-following vehicle. A slave-side beat carries either a
// pair of light samples or a setup button press (s_tuser). Presses step calibration:
// dark level, reference level, light level with scale = track_width/|dark-light| from a
// serial divider, then run. In run with power on, each sample pair yields one
// master-side beat with power and direction of both wheels; other beats give none. A
// sample pair that steers runs from its accept through six operand steps on the single
// shared signed multiplier (sample width+27 by 25 bits), an accumulate step, a saturate
// step and the output step before the next accept. m_tvalid rises as the output step
// ends, and the output step holds while an earlier result beat waits. A press that
// starts the division keeps the block busy until the quotient is in; every other beat
// leaves the block idle. The block takes no new beat while a sample or the scale
// division is being worked on. The register file is written through the APB port at any
// time the block is idle.
module line_follow_steering_controller import lfsc_pkg::*; #(
	parameter int SAMPLE_BITS     = 10,
	parameter int SCALE_FRAC_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// front_sample, back_sample, power_on; zero padding above
	input  logic [((2*SAMPLE_BITS+8)/8)*8-1:0]   s_tdata,
	// kind
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// right_power, right_direction, left_power, left_direction; zero padding above
	output logic [M_TDATA_W-1:0]                 m_tdata,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [CFG_AW-1:0]                    paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);

	localparam int FW         = SAMPLE_BITS + 1;
	localparam int DYW        = SAMPLE_BITS + 2;
	localparam int MAW        = DYW + MUL_B_W;
	localparam int PW         = MAW + MUL_B_W;
	localparam int HW         = PW - HEADING_SHIFT;
	localparam int SUM_W      = (PW > 63 ? PW : 63) + 2;
	localparam int CORR_SHIFT = SCALE_FRAC_BITS + GAIN_FRAC;

	cfg_t cfg;
	state_t state_q, state_d;
	phase_t phase_q;

	logic [FW-1:0]          last_front_q;
	logic [SAMPLE_BITS-1:0] last_back_q;
	logic [FW-1:0]          dark_q;
	logic [FW-1:0]          ref_q;
	logic [SCALE_W-1:0]     scale_q;

	logic [SAMPLE_BITS-1:0] in_front;
	logic [SAMPLE_BITS-1:0] in_back;
	logic                   in_power_on;
	logic                   in_beat;
	logic [FW-1:0]          front_diff;

	logic signed [DYW-1:0]     dy;
	logic signed [DYW-1:0]     db;
	logic [23:0]               gain_mag;
	logic signed [MAW-1:0]     mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]      prod_q;
	logic signed [HW-1:0]      head_val;

	logic signed [MAW-1:0] y_q;
	logic [HW-1:0]         ua_q;
	logic                  hneg_q;
	logic                  sat_q;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SUM_W-1:0] hik_sh;
	logic signed [SUM_W-1:0] lok_ext;
	logic [SUM_W-1:0]        sum_mag;
	logic [SUM_W-1:0]        quo_mag;
	logic [CORR_W-1:0]       corr_mag;
	logic signed [CORR_W-1:0] corr_q;

	logic signed [WHEEL_W-1:0] base_s;
	logic signed [WHEEL_W-1:0] corr_s;
	wheel_t right_w;
	wheel_t left_w;

	logic div_start;
	logic div_done;
	logic [SCALE_W-1:0] div_quo;

	logic out_free;
	logic out_load;
	logic m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	lfsc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lfsc_mul #(
		.AW (MAW),
		.BW (MUL_B_W)
	) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	lfsc_div #(
		.NW (SCALE_W),
		.DW (FW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cfg.track_width),
		.den    (front_diff),
		.done_q (div_done),
		.quo_q  (div_quo)
	);

	// Unpack the slave beat
	assign in_front    = s_tdata[SAMPLE_BITS-1:0];
	assign in_back     = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign in_power_on = s_tdata[2*SAMPLE_BITS];
	assign in_beat     = s_tvalid & s_tready;

	assign front_diff = (dark_q > last_front_q) ? dark_q - last_front_q
	                                            : last_front_q - dark_q;

	// Differences and gain magnitude
	assign dy       = signed'(DYW'(last_front_q) - DYW'(ref_q));
	assign db       = signed'(DYW'(last_front_q) - DYW'(last_back_q));
	assign gain_mag = cfg.heading_gain[23] ? 24'(-cfg.heading_gain) : cfg.heading_gain;
	assign head_val = prod_q[PW-1:HEADING_SHIFT];

	assign out_free = !m_tvalid_q || m_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == KIND_BUTTON) begin
						if (phase_q == PH_REF && front_diff != '0) state_d = ST_DIV;
					end else if (phase_q == PH_RUN && in_power_on) begin
						state_d = ST_MUL_Y;
					end
				end
			end
			ST_DIV:    if (div_done) state_d = ST_IDLE;
			ST_MUL_Y:  state_d = ST_MUL_T;
			ST_MUL_T:  state_d = ST_MUL_HF;
			ST_MUL_HF: state_d = ST_MUL_G1;
			ST_MUL_G1: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_ACC;
			ST_ACC:    state_d = ST_CORR;
			ST_CORR:   state_d = ST_OUT;
			ST_OUT:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, divider start, output load, multiplier operands
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				div_start = s_tvalid && s_tuser == KIND_BUTTON && phase_q == PH_REF
				            && front_diff != '0;
			end
			ST_MUL_Y: begin
				mul_a = MAW'(dy);
				mul_b = signed'(MUL_B_W'(scale_q));
			end
			ST_MUL_T: begin
				mul_a = MAW'(db);
				mul_b = signed'(MUL_B_W'(scale_q));
			end
			ST_MUL_HF: begin
				mul_a = prod_q[MAW-1:0];
				mul_b = signed'(MUL_B_W'(cfg.inv_spacing));
			end
			ST_MUL_G1: begin
				mul_a = y_q;
				mul_b = MUL_B_W'(cfg.offset_gain);
			end
			ST_MUL_HI: begin
				mul_a = signed'(MAW'(ua_q[HW-1:HI_SHIFT]));
				mul_b = signed'(MUL_B_W'(gain_mag));
			end
			ST_MUL_LO: begin
				mul_a = signed'(MAW'(ua_q[HI_SHIFT-1:0]));
				mul_b = signed'(MUL_B_W'(gain_mag));
			end
			ST_OUT:  out_load = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Calibration state and latest samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_UNCAL;
			last_front_q <= '0;
			last_back_q  <= '0;
			dark_q       <= '0;
			ref_q        <= '0;
			scale_q      <= '0;
		end else if (in_beat) begin
			if (s_tuser == KIND_BUTTON) begin
				case (phase_q)
					PH_UNCAL, PH_RUN: begin
						phase_q <= PH_DARK;
						dark_q  <= last_front_q;
					end
					PH_DARK: begin
						phase_q <= PH_REF;
						ref_q   <= last_front_q;
					end
					PH_REF: begin
						phase_q <= PH_SCALE;
						if (front_diff == '0) scale_q <= SCALE_MAX;
					end
					default: phase_q <= PH_RUN;
				endcase
			end else begin
				last_front_q <= FW'(in_front) + FW'(FRONT_OFFSET);
				last_back_q  <= in_back;
			end
		end else if (state_q == ST_DIV && div_done) begin
			scale_q <= div_quo;
		end
	end

	// Accumulate the correction from the multiplier results
	assign hik_sh  = SUM_W'(prod_q) << HI_SHIFT;
	assign lok_ext = SUM_W'(prod_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL_T: y_q <= prod_q[MAW-1:0];
			ST_MUL_G1: begin
				ua_q   <= head_val[HW-1] ? HW'(-head_val) : head_val;
				hneg_q <= prod_q[PW-1] ^ cfg.heading_gain[23];
			end
			ST_MUL_HI: acc_q <= SUM_W'(prod_q);
			ST_MUL_LO: begin
				sat_q <= prod_q[PW-2:SAT_LIMIT_BIT] != '0;
				acc_q <= hneg_q ? acc_q - hik_sh : acc_q + hik_sh;
			end
			ST_ACC: acc_q <= hneg_q ? acc_q - lok_ext : acc_q + lok_ext;
			ST_CORR: begin
				if (sat_q) corr_q <= hneg_q ? -CORR_W'(CORR_MAX) : CORR_W'(CORR_MAX);
				else corr_q <= acc_q[SUM_W-1] ? -signed'(corr_mag) : signed'(corr_mag);
			end
			default: begin
			end
		endcase
	end

	// Scale the sum down and saturate
	always_comb begin
		sum_mag = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : acc_q;
		quo_mag = sum_mag >> CORR_SHIFT;
		if (quo_mag > SUM_W'(CORR_MAX)) corr_mag = CORR_W'(CORR_MAX);
		else corr_mag = quo_mag[CORR_W-1:0];
	end

	// Wheel commands
	assign base_s  = signed'(WHEEL_W'(cfg.base_power));
	assign corr_s  = WHEEL_W'(corr_q);
	assign right_w = drive(base_s + corr_s, cfg.min_power, cfg.max_power);
	assign left_w  = drive(base_s - corr_s, cfg.min_power, cfg.max_power);

	// Output register: hold the beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid_q <= 1'b0;
		else if (out_load) m_tvalid_q <= 1'b1;
		else if (m_tready) m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= M_TDATA_W'({left_w.dir, left_w.power, right_w.dir, right_w.power});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/lfsc_checker.sv]
module lfsc_checker import lfsc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// Stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Direction codes stay within forward, reverse and brake
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:8] != 2'd3 && m_tdata[19:18] != 2'd3)
		else $error("invalid wheel direction code");

	// Brake always comes with zero power
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[9:8] == DIR_BRAKE || m_tdata[19:18] == DIR_BRAKE) |->
		(m_tdata[9:8] != DIR_BRAKE || m_tdata[7:0] == 8'd0) &&
		(m_tdata[19:18] != DIR_BRAKE || m_tdata[17:10] == 8'd0))
		else $error("brake with nonzero power");

	// A button press produces no result
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_BUTTON && !m_tvalid |=> !m_tvalid)
		else $error("result after button press");

endmodule

bind line_follow_steering_controller lfsc_checker u_lfsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[bench/steer_predict_check.sv]
module steer_predict_check import lfsc_pkg::*; #(
	parameter int SAMPLE_BITS = 10,
	parameter int S_TDATA_W   = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// front_sample, back_sample, power_on; zero padding above
	input  logic [S_TDATA_W-1:0] s_tdata,
	// kind
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// right_power, right_direction, left_power, left_direction; zero padding above
	input  logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic                 pready,
	input  logic [CFG_AW-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	// Wheel commands in m_tdata order, right_power in the lowest bits
	typedef struct packed {
		logic [1:0] left_dir;
		logic [7:0] left_power;
		logic [1:0] right_dir;
		logic [7:0] right_power;
	} motor_cmd_t;

	cfg_t                  cfg;
	phase_t                cal_phase;
	logic [10:0]           front_lvl;
	logic [SAMPLE_BITS-1:0] back_lvl;
	logic [10:0]           dark_lvl;
	logic [10:0]           ref_lvl;
	logic [SCALE_W-1:0]    count_scale;
	motor_cmd_t            cmd_q[$];
	int                    misses;

	// Dead band first, then clamp; zero command brakes
	function automatic void wheel_drive(input longint v, output logic [7:0] pw,
			output logic [1:0] dir);
		longint mag;
		if (v > 0) begin
			dir = DIR_FWD;
			mag = v;
		end else if (v < 0) begin
			dir = DIR_REV;
			mag = -v;
		end else begin
			dir = DIR_BRAKE;
			mag = 0;
		end
		if (mag < longint'(cfg.min_power)) begin
			mag = 0;
			dir = DIR_BRAKE;
		end else if (mag > longint'(cfg.max_power)) begin
			mag = longint'(cfg.max_power);
		end
		pw = mag[7:0];
	endfunction

	// Advance calibration on a press, or compute the wheel command for a sample pair
	task automatic take_beat(input logic kind, input logic [S_TDATA_W-1:0] data);
		logic [10:0]     diff;
		longint          dy, db, scl, y, hf, heading, term1, hgain, sum, corr;
		longint unsigned ua, k, hi, lo, p, us, qv;
		logic            flip;
		motor_cmd_t      cmd;
		if (kind == KIND_BUTTON) begin
			case (cal_phase)
				PH_UNCAL, PH_RUN: begin
					cal_phase = PH_DARK;
					dark_lvl = front_lvl;
				end
				PH_DARK: begin
					cal_phase = PH_REF;
					ref_lvl = front_lvl;
				end
				PH_REF: begin
					diff = (dark_lvl > front_lvl) ? dark_lvl - front_lvl : front_lvl - dark_lvl;
					cal_phase = PH_SCALE;
					if (diff == '0)
						count_scale = SCALE_MAX;
					else
						count_scale = SCALE_W'(cfg.track_width / SCALE_W'(diff));
				end
				default: cal_phase = PH_RUN;
			endcase
		end else begin
			front_lvl = 11'(data[SAMPLE_BITS-1:0]) + 11'(FRONT_OFFSET);
			back_lvl = data[2*SAMPLE_BITS-1:SAMPLE_BITS];
			if (cal_phase == PH_RUN && data[2*SAMPLE_BITS]) begin
				dy = longint'(front_lvl) - longint'(ref_lvl);
				db = longint'(front_lvl) - longint'(back_lvl);
				scl = longint'(count_scale);
				y = dy * scl;
				hf = db * scl * longint'(cfg.inv_spacing);
				heading = hf >>> HEADING_SHIFT;
				term1 = longint'(cfg.offset_gain) * y;
				hgain = longint'(cfg.heading_gain);
				ua = (heading < 0) ? -heading : heading;
				k = (hgain < 0) ? -hgain : hgain;
				flip = (heading < 0) != (hgain < 0);
				hi = ua >> HI_SHIFT;
				lo = ua & 64'hFFFF_FFFF;
				// Saturate when the heading term alone is out of range
				if (hi * k >= (64'd1 << SAT_LIMIT_BIT)) begin
					corr = flip ? -CORR_MAX : CORR_MAX;
				end else begin
					p = ((hi * k) << HI_SHIFT) + lo * k;
					sum = term1 + (flip ? -longint'(p) : longint'(p));
					us = (sum < 0) ? -sum : sum;
					qv = us >> (SCALE_W + GAIN_FRAC);
					if (qv > CORR_MAX)
						qv = CORR_MAX;
					corr = (sum < 0) ? -longint'(qv) : longint'(qv);
				end
				wheel_drive(longint'(cfg.base_power) + corr, cmd.right_power, cmd.right_dir);
				wheel_drive(longint'(cfg.base_power) - corr, cmd.left_power, cmd.left_dir);
				cmd_q.push_back(cmd);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		motor_cmd_t got, want;
		if (!arst_n) begin
			cfg.track_width = RST_TRACK_WIDTH;
			cfg.inv_spacing = RST_INV_SPACING;
			cfg.offset_gain = RST_OFFSET_GAIN;
			cfg.heading_gain = RST_HEADING_GAIN;
			cfg.base_power = RST_BASE_POWER;
			cfg.min_power = RST_MIN_POWER;
			cfg.max_power = RST_MAX_POWER;
			cal_phase = PH_UNCAL;
			front_lvl = '0;
			back_lvl = '0;
			dark_lvl = '0;
			ref_lvl = '0;
			count_scale = '0;
			cmd_q.delete();
			misses = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Compare a result beat with the oldest expected command
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(motor_cmd_t)-1:0];
				if (cmd_q.size() == 0) begin
					misses++;
					if (misses <= REPORT_LIMIT)
						$display("%0t: unexpected result beat R %0d/%0d L %0d/%0d", $realtime,
							got.right_power, got.right_dir, got.left_power, got.left_dir);
				end else begin
					want = cmd_q.pop_front();
					if (got.right_power !== want.right_power || got.right_dir !== want.right_dir ||
							got.left_power !== want.left_power || got.left_dir !== want.left_dir) begin
						misses++;
						if (misses <= REPORT_LIMIT)
							$display("%0t: wheel mismatch, expected R %0d/%0d L %0d/%0d, got R %0d/%0d L %0d/%0d",
								$realtime, want.right_power, want.right_dir, want.left_power,
								want.left_dir, got.right_power, got.right_dir, got.left_power,
								got.left_dir);
					end
				end
			end
			// Predict from each accepted input beat
			if (s_tvalid && s_tready)
				take_beat(s_tuser, s_tdata);
			// Mirror register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_AW-1:2])
					REG_TRACK_WIDTH:  cfg.track_width = pwdata[23:0];
					REG_INV_SPACING:  cfg.inv_spacing = pwdata[15:0];
					REG_OFFSET_GAIN:  cfg.offset_gain = pwdata[23:0];
					REG_HEADING_GAIN: cfg.heading_gain = pwdata[23:0];
					REG_BASE_POWER:   cfg.base_power = pwdata[7:0];
					REG_MIN_POWER:    cfg.min_power = pwdata[7:0];
					REG_MAX_POWER:    cfg.max_power = pwdata[7:0];
					default: ;
				endcase
			end
			fail_count <= misses;
			pending <= cmd_q.size();
		end
	end

endmodule

[bench/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lfsc_pkg::*;

	localparam int SAMPLE_BITS = 10;
	localparam int S_TDATA_W   = ((2*SAMPLE_BITS+8)/8)*8;
	// Longest work that yields no result: the scale division
	localparam int BUSY_CYCLES = 40;
	localparam int DRAIN_LIMIT = 20000;
	localparam int RUN_PHASES  = 8;
	localparam int PHASE_ITEMS = 130;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// front_sample, back_sample, power_on; zero padding above
	logic [S_TDATA_W-1:0] s_tdata;
	// kind
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// right_power, right_direction, left_power, left_direction; zero padding above
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [CFG_AW-1:0]    paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	int                   fail_count;
	int                   pending;

	// Stimulus-side view of the calibration sequence
	phase_t               cal_step = PH_UNCAL;
	logic [SAMPLE_BITS-1:0] last_raw = '0;
	logic [SAMPLE_BITS-1:0] dark_raw = '0;
	bit                   calm = 1'b0;

	line_follow_steering_controller #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SCALE_FRAC_BITS(24)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	steer_predict_check #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.S_TDATA_W(S_TDATA_W)
	) u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 4);
		else if (r < 96)
			return $urandom_range(5, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return '0;
		else if (r < 24)
			return '1;
		else
			return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
	endfunction

	function automatic logic signed [23:0] rand_gain();
		logic signed [23:0] g;
		g = 24'($urandom_range(0, 24'h7FFFFF) >> $urandom_range(0, 22));
		if ($urandom_range(0, 1))
			g = -g;
		return g;
	endfunction

	// Register settings per run phase: reset values, both extremes, then random
	function automatic cfg_t phase_setup(input int p);
		cfg_t c;
		case (p)
			0: begin
				c.track_width = RST_TRACK_WIDTH;
				c.inv_spacing = RST_INV_SPACING;
				c.offset_gain = RST_OFFSET_GAIN;
				c.heading_gain = RST_HEADING_GAIN;
				c.base_power = RST_BASE_POWER;
				c.min_power = RST_MIN_POWER;
				c.max_power = RST_MAX_POWER;
			end
			1: begin
				c.track_width = '0;
				c.inv_spacing = '0;
				c.offset_gain = 24'sh800000;
				c.heading_gain = 24'sh800000;
				c.base_power = '0;
				c.min_power = '0;
				c.max_power = '0;
			end
			2: begin
				c.track_width = '1;
				c.inv_spacing = '1;
				c.offset_gain = 24'sh7FFFFF;
				c.heading_gain = 24'sh7FFFFF;
				c.base_power = '1;
				c.min_power = '1;
				c.max_power = '1;
			end
			default: begin
				c.track_width = 24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 12));
				c.inv_spacing = 16'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 8));
				c.offset_gain = rand_gain();
				c.heading_gain = rand_gain();
				c.base_power = 8'($urandom_range(0, 255));
				c.min_power = 8'((p == 5) ? $urandom_range(150, 255) : $urandom_range(0, 40));
				c.max_power = 8'((p == 5) ? $urandom_range(0, 149) : $urandom_range(100, 255));
			end
		endcase
		return c;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_setup(input cfg_t c);
		reg_write(REG_TRACK_WIDTH, 32'(c.track_width));
		reg_write(REG_INV_SPACING, 32'(c.inv_spacing));
		reg_write(REG_OFFSET_GAIN, 32'(unsigned'(c.offset_gain)));
		reg_write(REG_HEADING_GAIN, 32'(unsigned'(c.heading_gain)));
		reg_write(REG_BASE_POWER, 32'(c.base_power));
		reg_write(REG_MIN_POWER, 32'(c.min_power));
		reg_write(REG_MAX_POWER, 32'(c.max_power));
	endtask

	// Hold the beat until accepted, track calibration, then idle at random
	task automatic send_item(input logic kind, input logic [SAMPLE_BITS-1:0] f,
			input logic [SAMPLE_BITS-1:0] b, input logic pwr);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= S_TDATA_W'({pwr, b, f});
		do @(posedge clk); while (!s_tready);
		if (kind == KIND_BUTTON) begin
			case (cal_step)
				PH_UNCAL, PH_RUN: begin
					cal_step = PH_DARK;
					dark_raw = last_raw;
				end
				PH_DARK: cal_step = PH_REF;
				PH_REF:  cal_step = PH_SCALE;
				default: cal_step = PH_RUN;
			endcase
		end else begin
			last_raw = f;
		end
		if ($urandom_range(0, 49) == 0)
			calm = !calm;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off until every result is out and any division has finished
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (BUSY_CYCLES) @(posedge clk);
	endtask

	// Mostly calibrate then run, with stray presses and power-off samples mixed in
	task automatic random_item();
		logic [SAMPLE_BITS-1:0] f, b;
		int r;
		r = $urandom_range(0, 99);
		f = pick_sample();
		if ($urandom_range(0, 2) == 0)
			b = f + SAMPLE_BITS'($urandom_range(0, 16)) - SAMPLE_BITS'(8);
		else
			b = pick_sample();
		if (cal_step != PH_RUN) begin
			if (cal_step == PH_REF && r < 15) begin
				send_item(KIND_SAMPLE, dark_raw, b, 1'b1);
				send_item(KIND_BUTTON, f, b, 1'b0);
			end else if (r < 40) begin
				send_item(KIND_SAMPLE, f, b, 1'($urandom_range(0, 1)));
			end else begin
				send_item(KIND_BUTTON, f, b, 1'($urandom_range(0, 1)));
			end
		end else if (r < 3) begin
			send_item(KIND_BUTTON, f, b, 1'b1);
		end else if (r < 4) begin
			drain();
		end else begin
			send_item(KIND_SAMPLE, f, b, r >= 13);
		end
	endtask

	// Result-side backpressure
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		cfg_t setup;
		int w;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_SAMPLE;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Calibrate with equal dark and light levels, then steer at the sample extremes
		send_item(KIND_SAMPLE, '0, '0, 1'b1);
		send_item(KIND_BUTTON, '0, '0, 1'b0);
		send_item(KIND_SAMPLE, '1, '1, 1'b1);
		send_item(KIND_BUTTON, '1, '1, 1'b1);
		send_item(KIND_SAMPLE, '0, '0, 1'b0);
		send_item(KIND_BUTTON, '0, '1, 1'b0);
		send_item(KIND_BUTTON, '1, '0, 1'b1);
		send_item(KIND_SAMPLE, '1, '0, 1'b1);
		send_item(KIND_SAMPLE, '0, '1, 1'b1);
		send_item(KIND_SAMPLE, 10'd512, 10'd512, 1'b0);
		send_item(KIND_SAMPLE, '0, '0, 1'b1);
		send_item(KIND_SAMPLE, 10'd1003, '1, 1'b1);

		// Huge heading term, and a dead band above the clamp
		drain();
		setup.track_width = '1;
		setup.inv_spacing = '1;
		setup.offset_gain = 24'sh7FFFFF;
		setup.heading_gain = 24'sh800000;
		setup.base_power = '0;
		setup.min_power = 8'd200;
		setup.max_power = 8'd100;
		write_setup(setup);
		send_item(KIND_SAMPLE, '1, '0, 1'b1);
		send_item(KIND_SAMPLE, '0, '1, 1'b1);
		send_item(KIND_SAMPLE, '0, '0, 1'b1);
		send_item(KIND_SAMPLE, 10'd10, 10'd10, 1'b1);

		// Recalibrate from run
		send_item(KIND_BUTTON, '0, '0, 1'b0);
		send_item(KIND_BUTTON, '0, '0, 1'b0);
		send_item(KIND_BUTTON, '0, '0, 1'b0);
		send_item(KIND_BUTTON, '0, '0, 1'b0);

		for (int p = 0; p < RUN_PHASES; p++) begin
			drain();
			write_setup(phase_setup(p));
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end

		// Let the last results out, then settle
		s_tvalid <= 1'b0;
		w = 0;
		do begin
			@(posedge clk);
			w++;
		end while (pending != 0 && w < DRAIN_LIMIT);
		repeat (BUSY_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/lfsc_pkg.sv
rtl/lfsc_cfg.sv
rtl/lfsc_mul.sv
rtl/lfsc_div.sv
rtl/line_follow_steering_controller.sv
rtl/lfsc_checker.sv
bench/steer_predict_check.sv
bench/tb_top.sv
